### sv/text_chunk_reassembler_core_defines.svh
// assertion macros shared by the reassembler rtl
`ifndef TEXT_CHUNK_REASSEMBLER_CORE_DEFINES_SVH
`define TEXT_CHUNK_REASSEMBLER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TCR_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define TCR_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

### sv/tcr_pkg.sv
// shared codes, types and helpers of the text chunk reassembler
package tcr_pkg;

  // opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  // result status codes
  localparam logic [3:0] ST_MID      = 4'd0;
  localparam logic [3:0] ST_PASS     = 4'd1;
  localparam logic [3:0] ST_STORED   = 4'd2;
  localparam logic [3:0] ST_COMPLETE = 4'd3;
  localparam logic [3:0] ST_BAD_SEQ  = 4'd4;
  localparam logic [3:0] ST_EMPTY    = 4'd5;
  localparam logic [3:0] ST_ORDER    = 4'd6;
  localparam logic [3:0] ST_OVERFLOW = 4'd7;
  localparam logic [3:0] ST_READ     = 4'd8;

  // header parser phases
  localparam logic [2:0] PH_SEQ0    = 3'd0;
  localparam logic [2:0] PH_SEQ     = 3'd1;
  localparam logic [2:0] PH_TOT0    = 3'd2;
  localparam logic [2:0] PH_TOT     = 3'd3;
  localparam logic [2:0] PH_BODY    = 3'd4;
  localparam logic [2:0] PH_PASS    = 3'd5;
  localparam logic [2:0] PH_BODYEND = 3'd6;

  // ascii bytes of the header
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [9:0] NUM_MAX = 10'd1023;

  typedef logic [9:0] num_t;

  // memory port enables
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } tcr_mem_ctl_t;

  // one decimal digit into a saturating 10-bit number
  function automatic num_t acc_digit(input num_t v, input logic [3:0] d);
    logic [13:0] n;
    n = 14'(v) * 14'd10 + 14'(d);
    return (n > 14'(NUM_MAX)) ? NUM_MAX : n[9:0];
  endfunction

endpackage

### sv/tcr_in_if.sv
// input word channel of the reassembler
interface tcr_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;
  logic       end_of_message;
  logic [7:0] read_index;

  modport source (output valid, output opcode, output data_byte, output end_of_message,
                  output read_index, input ready);
  modport sink (input valid, input opcode, input data_byte, input end_of_message,
                input read_index, output ready);
endinterface

### sv/tcr_out_if.sv
// result word channel of the reassembler
interface tcr_out_if #(
  parameter int LEN_W = 9
);
  logic             valid;
  logic             ready;
  logic [3:0]       status;
  logic [LEN_W-1:0] assembled_length;
  logic [7:0]       read_data;

  modport source (output valid, output status, output assembled_length, output read_data,
                  input ready);
  modport sink (input valid, input status, input assembled_length, input read_data,
                output ready);
endinterface

### sv/tcr_buffer.sv
// assembly buffer: one write port, one registered read port
module tcr_buffer
  import tcr_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  tcr_mem_ctl_t  ctl,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/text_chunk_reassembler_core.sv
// top level of the text chunk reassembler
//
//  channel  | dir | handshake     | word
//  ---------+-----+---------------+-----------------------------------------------
//  in_ch    | in  | valid / ready | opcode, data_byte, end_of_message, read_index
//  out_ch   | out | valid / ready | status, assembled_length, read_data
//
// one word accepted per cycle while in_ch.ready is high, one result per word, passed through
// the middle stage and the result register; parse and buffer write finish in the accept
// cycle; a read goes through the buffer's registered read port, whose data meets its status
// in the result stage; rst_n is synchronous; parse and assembly state return to their reset
// values, the buffer contents are not cleared, no clearing pass is run and in_ch.ready is
// low in reset; a stalled output fills the middle stage and then drops in_ch.ready
`include "text_chunk_reassembler_core_defines.svh"

module text_chunk_reassembler_core
  import tcr_pkg::*;
#(
  parameter int BUFFER_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  tcr_in_if.sink     in_ch,
  tcr_out_if.source  out_ch
);

  localparam int AW    = $clog2(BUFFER_BYTES);
  localparam int LEN_W = $clog2(BUFFER_BYTES + 1);   // lengths up to the full buffer
  localparam int CNT_W = $clog2(BUFFER_BYTES + 2);   // body count saturates one past it
  localparam int SUM_W = CNT_W + 1;

  // handshake
  logic in_accept;
  logic push_acc;
  logic p1_adv;

  // parse state
  logic [2:0]       phase_r, phase_nxt;
  num_t             seq_r, seq_nxt;
  num_t             tot_r, tot_nxt;
  logic [CNT_W-1:0] body_r, body_nxt;
  logic             act_r, act_nxt;
  num_t             exp_r, exp_nxt;
  logic [LEN_W-1:0] stored_r, stored_nxt;
  logic [LEN_W-1:0] wb_r, wb_nxt;

  // item result from the accept cycle
  logic [3:0]       res_status;
  logic [LEN_W-1:0] res_len;

  // middle stage
  logic             p1_valid_r;
  logic [3:0]       p1_status_r;
  logic [LEN_W-1:0] p1_len_r;
  logic             p1_rd_r;

  // result stage
  logic             out_valid_r;
  logic [3:0]       out_status_r;
  logic [LEN_W-1:0] out_len_r;
  logic [7:0]       out_data_r;

  // buffer port
  tcr_mem_ctl_t     mem_ctl;
  logic             body_wr;
  logic [SUM_W-1:0] wr_pos;
  logic [7:0]       mem_rd_data;

  // middle stage moves on when the result stage is free or being emptied
  assign p1_adv      = p1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = rst_n && (!p1_valid_r || p1_adv);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign push_acc    = in_accept && (in_ch.opcode == OP_PUSH);

  assign wr_pos = SUM_W'(wb_r) + SUM_W'(body_r);

  // byte parse and end-of-message outcome, all in the accept cycle
  always_comb begin
    logic             digit;
    logic [3:0]       dval;
    logic [2:0]       ph_i;
    num_t             seq_i;
    num_t             tot_i;
    logic [CNT_W-1:0] body_i;
    logic [LEN_W-1:0] wb_i;
    logic             restart_r;
    logic             hdr_ok;
    logic             restart_i;
    logic [SUM_W-1:0] sum_i;

    digit     = in_ch.data_byte inside {[CH_ZERO:CH_NINE]};
    dval      = in_ch.data_byte[3:0];
    ph_i      = phase_r;
    seq_i     = seq_r;
    tot_i     = tot_r;
    body_i    = body_r;
    wb_i      = wb_r;
    body_wr   = 1'b0;
    restart_r = !act_r || (seq_r == 10'd1);
    hdr_ok    = (tot_r > 10'd1) && (seq_r >= 10'd1) && (seq_r <= tot_r) &&
                ((restart_r ? 10'd1 : exp_r) == seq_r);

    act_nxt    = act_r;
    exp_nxt    = exp_r;
    stored_nxt = stored_r;
    res_status = ST_MID;
    res_len    = '0;

    case (phase_r)
      PH_SEQ0, PH_SEQ: begin
        if (digit) begin
          seq_i = acc_digit((phase_r == PH_SEQ) ? seq_r : 10'd0, dval);
          ph_i  = PH_SEQ;
        end else if (in_ch.data_byte == CH_SLASH && phase_r == PH_SEQ) begin
          ph_i = PH_TOT0;
        end else begin
          ph_i = PH_PASS;
        end
      end
      PH_TOT0, PH_TOT: begin
        if (digit) begin
          tot_i = acc_digit((phase_r == PH_TOT) ? tot_r : 10'd0, dval);
          ph_i  = PH_TOT;
        end else if (in_ch.data_byte == CH_BAR && phase_r == PH_TOT) begin
          ph_i = PH_BODY;
          wb_i = restart_r ? '0 : stored_r;
        end else begin
          ph_i = PH_PASS;
        end
      end
      PH_BODY: begin
        if (in_ch.data_byte == CH_NUL) begin
          ph_i = PH_BODYEND;
        end else begin
          // bytes past the buffer end are counted but not written
          body_wr = hdr_ok && (32'(wr_pos) < BUFFER_BYTES);
          if (32'(body_r) <= BUFFER_BYTES) begin
            body_i = body_r + CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase

    wb_nxt    = wb_i;
    restart_i = !act_r || (seq_i == 10'd1);
    sum_i     = '0;

    if (in_ch.end_of_message) begin
      if (!(ph_i == PH_BODY || ph_i == PH_BODYEND) || tot_i <= 10'd1) begin
        res_status = ST_PASS;
      end else if (seq_i == 10'd0 || seq_i > tot_i) begin
        act_nxt    = 1'b0;
        exp_nxt    = 10'd1;
        stored_nxt = '0;
        wb_nxt     = '0;
        res_status = ST_BAD_SEQ;
      end else if (body_i == '0) begin
        res_status = ST_EMPTY;
      end else begin
        if (restart_i) begin
          act_nxt    = 1'b1;
          exp_nxt    = 10'd1;
          stored_nxt = '0;
          wb_nxt     = '0;
        end
        sum_i = SUM_W'(wb_nxt) + SUM_W'(body_i);
        if (exp_nxt != seq_i || 32'(sum_i) > BUFFER_BYTES) begin
          res_status = (exp_nxt != seq_i) ? ST_ORDER : ST_OVERFLOW;
          act_nxt    = 1'b0;
          exp_nxt    = 10'd1;
          stored_nxt = '0;
          wb_nxt     = '0;
        end else if (seq_i == tot_i) begin
          // last chunk: report the length, drop the assembly, bytes stay readable
          res_status = ST_COMPLETE;
          res_len    = LEN_W'(sum_i);
          act_nxt    = 1'b0;
          exp_nxt    = 10'd1;
          stored_nxt = '0;
          wb_nxt     = '0;
        end else begin
          res_status = ST_STORED;
          stored_nxt = LEN_W'(sum_i);
          exp_nxt    = exp_nxt + 10'd1;
        end
      end
      phase_nxt = PH_SEQ0;
      seq_nxt   = '0;
      tot_nxt   = '0;
      body_nxt  = '0;
    end else begin
      phase_nxt = ph_i;
      seq_nxt   = seq_i;
      tot_nxt   = tot_i;
      body_nxt  = body_i;
    end
  end

  // parse and assembly state, changed by pushes only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEQ0;
      seq_r    <= '0;
      tot_r    <= '0;
      body_r   <= '0;
      act_r    <= 1'b0;
      exp_r    <= 10'd1;
      stored_r <= '0;
      wb_r     <= '0;
    end else if (push_acc) begin
      phase_r  <= phase_nxt;
      seq_r    <= seq_nxt;
      tot_r    <= tot_nxt;
      body_r   <= body_nxt;
      act_r    <= act_nxt;
      exp_r    <= exp_nxt;
      stored_r <= stored_nxt;
      wb_r     <= wb_nxt;
    end
  end

  // buffer access: body byte write on a push, lookup on every read (zero data if out of range)
  assign mem_ctl.wr_en = push_acc && body_wr;
  assign mem_ctl.rd_en = in_accept && (in_ch.opcode == OP_READ);

  tcr_buffer #(
    .DEPTH (BUFFER_BYTES),
    .AW    (AW)
  ) u_buffer (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (wr_pos[AW-1:0]),
    .wr_data (in_ch.data_byte),
    .rd_addr (AW'(in_ch.read_index)),
    .rd_data (mem_rd_data)
  );

  // middle stage waits for the buffer read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (in_accept) begin
      p1_valid_r <= 1'b1;
    end else if (p1_adv) begin
      p1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      p1_status_r <= (in_ch.opcode == OP_READ) ? ST_READ : res_status;
      p1_len_r    <= (in_ch.opcode == OP_READ) ? '0 : res_len;
      p1_rd_r     <= (in_ch.opcode == OP_READ) && (32'(in_ch.read_index) < BUFFER_BYTES);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_adv) begin
      out_status_r <= p1_status_r;
      out_len_r    <= p1_len_r;
      out_data_r   <= p1_rd_r ? mem_rd_data : 8'd0;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_status_r;
  assign out_ch.assembled_length = out_len_r;
  assign out_ch.read_data        = out_data_r;

  // checks
  `TCR_ASSERT_NOW(a_wr_in_buffer, mem_ctl.wr_en, 32'(wr_pos) < BUFFER_BYTES,
    "buffer write beyond its end")
  `TCR_ASSERT_NEXT(a_p1_holds, p1_valid_r && !p1_adv,
    p1_valid_r && $stable(p1_status_r) && $stable(p1_len_r),
    "middle stage lost its word under stall")
  `TCR_ASSERT_NOW(a_len_only_complete, out_valid_r && out_status_r != ST_COMPLETE,
    out_len_r == '0, "length shown without completion")
  `TCR_ASSERT_NOW(a_stored_bound, act_r || stored_r == '0, 32'(stored_r) <= BUFFER_BYTES,
    "stored length beyond buffer")
  `TCR_ASSERT_NOW(a_one_port_op, mem_ctl.wr_en, !mem_ctl.rd_en,
    "buffer read and write in one cycle")

endmodule

### verif/text_chunk_reassembler_core_tb.sv
// self-checking testbench of the text chunk reassembler core
`timescale 1ns / 100ps

module text_chunk_reassembler_core_tb;
  import tcr_pkg::*;

  localparam int BUFFER_BYTES = 256;
  // cycles with no handshake on either side before the run is called hung
  localparam int STALL_LIMIT  = 400;
  localparam int RANDOM_WORDS = 250;

  typedef logic [7:0] octet_q_t[$];

  // one input word as the sender sees it
  typedef struct packed {
    logic       opcode;
    logic [7:0] data;
    logic       eom;
    logic [7:0] idx;
  } in_word_t;

  // one result word as the checker sees it
  typedef struct packed {
    logic [3:0] status;
    logic [8:0] length;
    logic [7:0] rdata;
  } result_t;

  logic clk;
  logic rst_n;

  tcr_in_if  in_ch ();
  tcr_out_if out_ch ();

  text_chunk_reassembler_core #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // shared run state
  result_t expected_results[$];
  int      mismatches  = 0;
  int      words_sent  = 0;
  int      gap_pct     = 0;   // chance of an input gap before a word
  int      stall_pct   = 0;   // chance of a result stall per cycle
  int      read_pct    = 0;   // chance of a read slipped in before a pushed byte
  bit      calm        = 1'b0;

  // predictor copy of the parser and assembly state
  logic [2:0] ph;
  int         seq_n;
  int         tot_n;
  int         body_n;
  bit         asm_active;
  int         exp_seq;
  int         stored_len;
  int         wbase;
  logic [7:0] mem [BUFFER_BYTES];
  bit         mem_ok [BUFFER_BYTES];
  int         filled[$];  // buffer positions written at least once, safe to read

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic int add_digit(input int v, input logic [7:0] b);
    int n;
    n = v * 10 + int'(b - CH_ZERO);
    return (n > int'(NUM_MAX)) ? int'(NUM_MAX) : n;
  endfunction

  // an inactive assembly or sequence 1 begins a fresh assembly
  function automatic bit fresh_start();
    return !asm_active || seq_n == 1;
  endfunction

  // body bytes only land in the buffer when the header would be taken
  function automatic bit chunk_accepted();
    int want_seq;
    want_seq = fresh_start() ? 1 : exp_seq;
    return tot_n > 1 && seq_n >= 1 && seq_n <= tot_n && want_seq == seq_n;
  endfunction

  function automatic void drop_assembly();
    asm_active = 1'b0;
    exp_seq    = 1;
    stored_len = 0;
    wbase      = 0;
  endfunction

  // outcome on the last byte of a message, in priority order
  function automatic logic [3:0] close_message(output logic [8:0] len);
    len = '0;
    if (ph != PH_BODY && ph != PH_BODYEND) return ST_PASS;
    if (tot_n <= 1) return ST_PASS;
    if (seq_n == 0 || seq_n > tot_n) begin
      drop_assembly();
      return ST_BAD_SEQ;
    end
    // empty body leaves everything as it was
    if (body_n == 0) return ST_EMPTY;
    if (fresh_start()) begin
      drop_assembly();
      asm_active = 1'b1;
    end
    if (exp_seq != seq_n) begin
      drop_assembly();
      return ST_ORDER;
    end
    if (wbase + body_n > BUFFER_BYTES) begin
      drop_assembly();
      return ST_OVERFLOW;
    end
    stored_len = wbase + body_n;
    exp_seq    = (exp_seq + 1) & 10'h3FF;
    if (seq_n == tot_n) begin
      // bytes stay readable after the assembly is cleared
      len = stored_len[8:0];
      drop_assembly();
      return ST_COMPLETE;
    end
    return ST_STORED;
  endfunction

  function automatic void reset_model();
    ph     = PH_SEQ0;
    seq_n  = 0;
    tot_n  = 0;
    body_n = 0;
    drop_assembly();
    foreach (mem_ok[i]) mem_ok[i] = 1'b0;
    filled.delete();
  endfunction

  // advance the predictor by one accepted word and return its result
  function automatic result_t reassemble_word(input in_word_t w);
    result_t    r;
    bit         dig;
    int         pos;
    logic [8:0] len9;
    r   = '0;
    dig = (w.data >= CH_ZERO) && (w.data <= CH_NINE);
    if (w.opcode == OP_READ) begin
      // end mark ignored, parse state untouched
      r.status = ST_READ;
      r.rdata  = mem[w.idx];
      return r;
    end
    case (ph)
      PH_SEQ0, PH_SEQ: begin
        if (dig) begin
          seq_n = add_digit((ph == PH_SEQ) ? seq_n : 0, w.data);
          ph    = PH_SEQ;
        end else if (w.data == CH_SLASH && ph == PH_SEQ) begin
          ph = PH_TOT0;
        end else begin
          ph = PH_PASS;
        end
      end
      PH_TOT0, PH_TOT: begin
        if (dig) begin
          tot_n = add_digit((ph == PH_TOT) ? tot_n : 0, w.data);
          ph    = PH_TOT;
        end else if (w.data == CH_BAR && ph == PH_TOT) begin
          ph    = PH_BODY;
          wbase = fresh_start() ? 0 : stored_len;
        end else begin
          ph = PH_PASS;
        end
      end
      PH_BODY: begin
        if (w.data == CH_NUL) begin
          // text ends here, later bytes are not counted
          ph = PH_BODYEND;
        end else begin
          pos = wbase + body_n;
          if (chunk_accepted() && pos < BUFFER_BYTES) begin
            mem[pos] = w.data;
            if (!mem_ok[pos]) begin
              mem_ok[pos] = 1'b1;
              filled.push_back(pos);
            end
          end
          if (body_n <= BUFFER_BYTES) body_n++;
        end
      end
      default: begin
      end
    endcase
    if (w.eom) begin
      r.status = close_message(len9);
      r.length = len9;
      ph       = PH_SEQ0;
      seq_n    = 0;
      tot_n    = 0;
      body_n   = 0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // message building
  // ---------------------------------------------------------------------------

  function automatic octet_q_t ascii(input string s);
    octet_q_t q;
    foreach (s[i]) q.push_back(s[i]);
    return q;
  endfunction

  // two pieces of text joined by a zero byte
  function automatic octet_q_t with_nul(input string a, input string b);
    octet_q_t q;
    q = ascii(a);
    q.push_back(CH_NUL);
    foreach (b[i]) q.push_back(b[i]);
    return q;
  endfunction

  // header "seq/tot|" followed by n random non-zero body bytes
  function automatic octet_q_t chunk(input int seq, input int tot, input int n);
    octet_q_t q;
    q = ascii($sformatf("%0d/%0d|", seq, tot));
    repeat (n) q.push_back(8'($urandom_range(1, 255)));
    return q;
  endfunction

  // bytes that tend to hit the header parser's decisions
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 4))
      0:       return CH_ZERO + 8'($urandom_range(0, 9));
      1:       return CH_SLASH;
      2:       return CH_BAR;
      3:       return CH_NUL;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int rand_body_bytes();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5)  return 0;
    if (roll < 93) return $urandom_range(1, 12);
    return $urandom_range(40, 120);
  endfunction

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // valid is only lowered inside a gap, so a back-to-back word never sees
  // a low and a high assignment in the same step
  task automatic send_word(input in_word_t w);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.opcode         <= w.opcode;
    in_ch.data_byte      <= w.data;
    in_ch.end_of_message <= w.eom;
    in_ch.read_index     <= w.idx;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(reassemble_word(w));
    words_sent++;
  endtask

  task automatic send_read(input logic [7:0] idx, input bit last);
    in_word_t w;
    w.opcode = OP_READ;
    w.data   = 8'($urandom_range(0, 255));
    w.eom    = last;
    w.idx    = idx;
    send_word(w);
  endtask

  task automatic read_somewhere();
    if (filled.size() != 0)
      send_read(8'(filled[$urandom_range(0, filled.size() - 1)]), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_push(input logic [7:0] b, input bit last);
    in_word_t w;
    w.opcode = OP_PUSH;
    w.data   = b;
    w.eom    = last;
    w.idx    = 8'($urandom_range(0, 255));
    send_word(w);
  endtask

  // whole message, end mark on its last byte, reads slipped in at random
  task automatic push_message(input octet_q_t m);
    foreach (m[i]) begin
      if (read_pct != 0 && $urandom_range(0, 99) < read_pct) read_somewhere();
      send_push(m[i], i == m.size() - 1);
    end
  endtask

  task automatic set_pace();
    case ($urandom_range(0, 3))
      0:       gap_pct = 0;
      1:       gap_pct = 5;
      2:       gap_pct = 25;
      default: gap_pct = 60;
    endcase
    case ($urandom_range(0, 3))
      0:       stall_pct = 0;
      1:       stall_pct = 3;
      2:       stall_pct = 15;
      default: stall_pct = 40;
    endcase
  endtask

  // result side stalls in bursts, none once the run has gone calm
  initial begin : result_backpressure
    out_ch.ready <= 1'b1;
    @(posedge clk);
    forever begin
      if (!calm && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 100) $display("mismatch at %0t: %s", $time, what);
  endtask

  // every result is matched against the oldest prediction
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result word with nothing expected, status %0d",
                                  out_ch.status));
      end else begin
        want = expected_results.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_ch.status, want.status));
        if (out_ch.assembled_length !== want.length)
          report_mismatch($sformatf("assembled_length %0d, want %0d (status %0d)",
                                    out_ch.assembled_length, want.length, want.status));
        if (out_ch.read_data !== want.rdata)
          report_mismatch($sformatf("read_data %0h, want %0h (status %0d)",
                                    out_ch.read_data, want.rdata, want.status));
      end
    end
  end

  // hang detector: counts cycles in which no word moves on either channel
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
    $display("** text_chunk_reassembler_core: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // anything short of a clean header with a total above one goes straight through
  task automatic test_pass_through();
    push_message(ascii("hello"));
    push_message(ascii(" 1/2|ab"));        // leading whitespace
    push_message(ascii("+1/2|ab"));        // sign
    push_message(ascii("1/|ab"));          // no total digits
    push_message(ascii("/2|ab"));          // no sequence digits
    push_message(ascii("1/2x|ab"));        // wrong separator
    push_message(ascii("1/1|ab"));         // single-chunk total
    push_message(ascii("1/0|ab"));
    push_message(with_nul("1", "/2|a"));   // zero byte inside the header
    push_message(ascii("12/3"));           // ends inside the header
    send_push(CH_ZERO + 8'd7, 1'b1);       // one-byte message
  endtask

  // three chunks in order, a read in the middle of one, then the bytes back
  task automatic test_in_order_assembly();
    octet_q_t m;
    push_message(ascii("1/3|abc"));
    m = ascii("2/3|de");
    for (int i = 0; i < 4; i++) send_push(m[i], 1'b0);
    send_read(8'd1, 1'b1);                 // end mark on a read is ignored
    send_push(m[4], 1'b0);
    send_push(m[5], 1'b1);
    push_message(ascii("3/3|f"));
    for (int i = 0; i < 6; i++) send_read(8'(i), 1'(i & 1));
  endtask

  task automatic test_bad_sequence();
    push_message(ascii("1/3|xy"));
    push_message(ascii("0/3|q"));
    push_message(ascii("1/2|a"));
    push_message(ascii("5/2|q"));
    push_message(ascii("2/2|z"));          // assembly was cleared, so out of order
  endtask

  // an empty body, also one cut short by a zero byte, changes nothing
  task automatic test_empty_body();
    push_message(ascii("1/2|k"));
    push_message(ascii("2/2|"));
    push_message(with_nul("2/2|", "zz"));
    push_message(ascii("2/2|m"));
  endtask

  task automatic test_nul_in_body();
    push_message(with_nul("1/2|ab", "cd"));
    push_message(ascii("2/2|e"));
    for (int i = 0; i < 3; i++) send_read(8'(i), 1'b0);
  endtask

  task automatic test_out_of_order();
    push_message(ascii("1/3|a"));
    push_message(ascii("3/3|b"));
    push_message(ascii("2/3|c"));
  endtask

  // numbers past 1023 stick at 1023
  task automatic test_number_saturation();
    push_message(ascii("99999/99999|a"));
    push_message(ascii("1/99999|a"));
    push_message(ascii("2/99999|b"));
    push_message(ascii("1023/1023|c"));
  endtask

  // also leaves every buffer entry written, so any read index is fair game
  task automatic test_overflow();
    push_message(chunk(1, 3, 200));
    push_message(chunk(2, 3, 55));
    push_message(chunk(3, 3, 1));          // completes at the full buffer size
    push_message(chunk(1, 3, 5));
    // body count saturates and bytes spill past the stored part
    push_message(chunk(2, 3, BUFFER_BYTES + 4));
    send_read(8'd255, 1'b0);
    send_read(8'd0, 1'b1);
    send_read(8'd150, 1'b0);
  endtask

  // mostly well-formed chunk sequences, with noise, bad headers and reads mixed in
  task automatic test_random_traffic();
    int       stop_at;
    int       kind;
    int       tot;
    int       seq;
    int       n;
    octet_q_t m;
    stop_at  = words_sent + RANDOM_WORDS;
    read_pct = 6;
    while (words_sent < stop_at) begin
      set_pace();
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        tot = $urandom_range(2, 5);
        for (int s = 1; s <= tot; s++) begin
          seq = s;
          if ($urandom_range(0, 11) == 0) seq = $urandom_range(0, tot + 1);
          n = rand_body_bytes();
          m = chunk(seq, tot, n);
          if (n != 0 && $urandom_range(0, 19) == 0)
            m[$urandom_range(m.size() - n, m.size() - 1)] = CH_NUL;
          push_message(m);
        end
      end else if (kind < 80) begin
        m.delete();
        repeat ($urandom_range(1, 8)) m.push_back(noise_byte());
        push_message(m);
      end else if (kind < 90) begin
        n = $urandom_range(0, 6);
        m = chunk($urandom_range(0, 1100), $urandom_range(0, 1100), n);
        if ($urandom_range(0, 1) == 0) m[$urandom_range(0, m.size() - n - 1)] = noise_byte();
        push_message(m);
      end else begin
        repeat ($urandom_range(1, 6)) read_somewhere();
      end
    end
  endtask

  // closing stretch with no idling on either side
  task automatic test_steady_stream();
    calm      = 1'b1;
    gap_pct   = 0;
    stall_pct = 0;
    read_pct  = 10;
    repeat (3) begin
      for (int s = 1; s <= 3; s++) push_message(chunk(s, 3, $urandom_range(1, 12)));
    end
    repeat (8) read_somewhere();
    in_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------------

  initial begin
    in_ch.valid          <= 1'b0;
    in_ch.opcode         <= OP_PUSH;
    in_ch.data_byte      <= '0;
    in_ch.end_of_message <= 1'b0;
    in_ch.read_index     <= '0;
    rst_n                <= 1'b0;
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_pass_through();
    test_in_order_assembly();
    test_bad_sequence();
    test_empty_body();
    test_nul_in_body();
    test_out_of_order();
    test_number_saturation();
    test_overflow();
    test_random_traffic();
    test_steady_stream();

    // drain; the watchdog bounds this wait
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0)
      $display("** text_chunk_reassembler_core: PASSED **");
    else
      $display("** text_chunk_reassembler_core: FAILED **");
    $finish;
  end

endmodule
